/* rtl/core/ipla_pkg.sv */
// Shared types and constants of the interval packet length averager.
package ipla_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_KLOAD,
        S_KWAIT,
        S_MUL,
        S_NBUPD,
        S_NUM1,
        S_NUM2,
        S_DLOAD,
        S_DWAIT,
        S_EMIT
    } t_state;

    // Load request of the shared divider: start value of the partial
    // remainder, dividend bits to shift in (MSB first), divisor, step count.
    typedef struct packed {
        logic        load;
        logic [5:0]  steps;
        logic [31:0] rem;
        logic [31:0] quo;
        logic [31:0] den;
    } t_div_req;

    localparam logic [5:0]  DIV_STEPS_GAP = 6'd32;
    localparam logic [5:0]  DIV_STEPS_AVG = 6'd23;
    localparam logic [22:0] AVG_MAX       = 23'd6553500;
    localparam logic [15:0] IVL_RESET     = 16'd10;
    localparam logic [31:0] CNT_MAX       = 32'hFFFF_FFFF;
    localparam logic [47:0] SUM_MAX       = 48'hFFFF_FFFF_FFFF;

    function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [15:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {33'b0, b};
        return s[48] ? SUM_MAX : s[47:0];
    endfunction

endpackage

/* rtl/core/ipla_divider.sv */
// Shared restoring divider, one quotient bit per cycle.
module ipla_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ipla_pkg::t_div_req i_req,
    output logic              o_done,
    output logic [31:0]       o_quo
);
    import ipla_pkg::*;

    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_done;

    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;

    assign trial = {r_rem, r_quo[31]};
    assign ge    = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.load) begin
                r_cnt <= i_req.steps;
            end else if (r_cnt != 6'd0) begin
                r_cnt  <= r_cnt - 6'd1;
                r_done <= (r_cnt == 6'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.load) begin
            r_rem <= i_req.rem;
            r_quo <= i_req.quo;
            r_den <= i_req.den;
        end else if (r_cnt != 6'd0) begin
            // shift in the next dividend bit, subtract where it fits
            r_rem <= ge ? diff[31:0] : trial[31:0];
            r_quo <= {r_quo[30:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

/* rtl/core/interval_packet_length_averager_top.sv */
// Per-interval packet count and average length reporter, top level.
// Ordinary packet: accumulated as it is accepted, one packet per cycle while idle.
// Packet closing intervals: gap divide, multiply and boundary update, two average divides
//   on the shared divider (skipped when the count is zero), then one report per interval,
//   up to MAX_REPORTS; flush: the average divides and one report. The block is busy meanwhile.
// Synchronous active-low reset clears the packet count and sums and sets the interval to 10 s.
module interval_packet_length_averager_top #(
    parameter int MAX_REPORTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_operation,
    input  logic [31:0] i_timestamp_seconds,
    input  logic [15:0] i_wire_length,
    input  logic [15:0] i_capture_length,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_report_time,
    output logic [31:0] o_packet_total,
    output logic [22:0] o_wire_average_hundredths,
    output logic [22:0] o_capture_average_hundredths,
    output logic        o_interval_empty,
    output logic        o_gap_truncated,
    output logic        o_last_report
);
    import ipla_pkg::*;

    localparam int LW = $clog2(MAX_REPORTS + 1);

    t_state      r_state, n_state;
    logic [15:0] r_ivl;
    logic [15:0] ivl_eff;
    logic        r_started;
    logic [31:0] r_nb;
    logic [31:0] r_cnt;
    logic [47:0] r_wsum;
    logic [47:0] r_csum;

    logic        r_op;
    logic [31:0] r_ts;
    logic [15:0] r_wl;
    logic [15:0] r_cl;
    logic [31:0] r_time;
    logic [31:0] r_k;
    logic [47:0] r_prod;
    logic [LW-1:0] r_left;
    logic        r_trunc;
    logic        r_sel;
    logic [54:0] r_num;
    logic [22:0] r_wavg;
    logic [22:0] r_cavg;

    logic        r_ov;
    logic [31:0] r_o_time;
    logic [31:0] r_o_total;
    logic [22:0] r_o_wavg;
    logic [22:0] r_o_cavg;
    logic        r_o_empty;
    logic        r_o_trunc;
    logic        r_o_last;

    logic        in_fire;
    logic        is_gap;
    logic        out_free;
    logic        emit_fire;
    logic        emit_last;
    logic        cnt_zero;
    t_div_req    div_req;
    logic        div_done;
    logic [31:0] div_quo;
    logic [32:0] gap_num;
    logic [47:0] sel_sum;
    logic [22:0] avg_q;
    logic [48:0] nb_sum;
    logic [32:0] first_nb;

    assign ivl_eff   = (r_ivl == 16'd0) ? 16'd1 : r_ivl;
    assign in_fire   = i_in_valid && o_in_ready;
    assign is_gap    = r_started && (i_timestamp_seconds > r_nb);
    assign out_free  = !r_ov || i_out_ready;
    assign emit_last = (r_left == LW'(1));
    assign cnt_zero  = (r_cnt == 32'd0);
    assign gap_num   = {1'b0, r_ts} - {1'b0, r_nb} + {17'b0, ivl_eff} - 33'd1;
    assign sel_sum   = r_sel ? r_csum : r_wsum;
    assign avg_q     = (div_quo[22:0] > AVG_MAX) ? AVG_MAX : div_quo[22:0];
    assign nb_sum    = {17'b0, r_nb} + {1'b0, r_prod};
    assign first_nb  = {1'b0, i_timestamp_seconds} + {17'b0, ivl_eff};

    ipla_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_operation) begin
                        n_state = cnt_zero ? S_EMIT : S_NUM1;
                    end else if (is_gap) begin
                        n_state = S_KLOAD;
                    end
                end
            end
            S_KLOAD: n_state = S_KWAIT;
            S_KWAIT: begin
                if (div_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL:   n_state = S_NBUPD;
            S_NBUPD: n_state = cnt_zero ? S_EMIT : S_NUM1;
            S_NUM1:  n_state = S_NUM2;
            S_NUM2:  n_state = S_DLOAD;
            S_DLOAD: n_state = S_DWAIT;
            S_DWAIT: begin
                if (div_done) begin
                    n_state = r_sel ? S_EMIT : S_NUM1;
                end
            end
            S_EMIT: begin
                if (emit_fire && emit_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_ready    = 1'b0;
        emit_fire     = 1'b0;
        div_req.load  = 1'b0;
        div_req.steps = DIV_STEPS_AVG;
        div_req.rem   = r_num[54:23];
        div_req.quo   = {r_num[22:0], 9'b0};
        div_req.den   = r_cnt;
        case (r_state)
            S_IDLE:  o_in_ready = 1'b1;
            S_KLOAD: begin
                div_req.load  = 1'b1;
                div_req.steps = DIV_STEPS_GAP;
                div_req.rem   = {31'b0, gap_num[32]};
                div_req.quo   = gap_num[31:0];
                div_req.den   = {16'b0, ivl_eff};
            end
            S_DLOAD: div_req.load = 1'b1;
            S_EMIT:  emit_fire    = out_free;
            default: ;
        endcase
    end

    // state, counters and sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ivl     <= IVL_RESET;
            r_started <= 1'b0;
            r_nb      <= '0;
            r_cnt     <= '0;
            r_wsum    <= '0;
            r_csum    <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_ivl <= i_cfg_data;
            end
            if (r_state == S_IDLE && in_fire && !i_operation && !is_gap) begin
                if (!r_started) begin
                    r_started <= 1'b1;
                    r_nb      <= first_nb[32] ? CNT_MAX : first_nb[31:0];
                end
                if (r_cnt != CNT_MAX) begin
                    r_cnt  <= r_cnt + 32'd1;
                    r_wsum <= sat_add48(r_wsum, i_wire_length);
                    r_csum <= sat_add48(r_csum, i_capture_length);
                end
            end
            if (r_state == S_NBUPD) begin
                r_nb <= (nb_sum[48:32] != 17'd0) ? CNT_MAX : nb_sum[31:0];
            end
            if (emit_fire) begin
                if (emit_last && r_op) begin
                    r_started <= 1'b0;
                    r_nb      <= '0;
                    r_cnt     <= '0;
                    r_wsum    <= '0;
                    r_csum    <= '0;
                end else if (emit_last) begin
                    // counts restart with the packet that closed the gap
                    r_cnt  <= 32'd1;
                    r_wsum <= {32'b0, r_wl};
                    r_csum <= {32'b0, r_cl};
                end else begin
                    r_cnt  <= '0;
                    r_wsum <= '0;
                    r_csum <= '0;
                end
            end
            if (emit_fire) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // per-item working registers and output beat
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    r_op    <= i_operation;
                    r_ts    <= i_timestamp_seconds;
                    r_wl    <= i_wire_length;
                    r_cl    <= i_capture_length;
                    r_time  <= r_started ? r_nb : 32'd0;
                    r_sel   <= 1'b0;
                    r_left  <= LW'(1);
                    r_trunc <= 1'b0;
                end
            end
            S_KWAIT: begin
                if (div_done) begin
                    r_k <= div_quo;
                end
            end
            S_MUL: begin
                r_prod  <= 48'(r_k) * 48'(ivl_eff);
                r_trunc <= r_k > 32'(MAX_REPORTS);
                r_left  <= (r_k > 32'(MAX_REPORTS)) ? LW'(MAX_REPORTS) : r_k[LW-1:0];
            end
            S_NUM1: begin
                r_num <= {1'b0, sel_sum, 6'b0} + {2'b0, sel_sum, 5'b0};
            end
            S_NUM2: begin
                r_num <= r_num + {5'b0, sel_sum, 2'b0} + {24'b0, r_cnt[31:1]};
            end
            S_DWAIT: begin
                if (div_done) begin
                    if (r_sel) begin
                        r_cavg <= avg_q;
                    end else begin
                        r_wavg <= avg_q;
                    end
                    r_sel <= 1'b1;
                end
            end
            S_EMIT: begin
                if (emit_fire) begin
                    r_time <= r_time + {16'b0, ivl_eff};
                    r_left <= r_left - LW'(1);
                end
            end
            default: ;
        endcase
        if (emit_fire) begin
            r_o_time  <= r_time;
            r_o_total <= r_cnt;
            r_o_wavg  <= cnt_zero ? 23'd0 : r_wavg;
            r_o_cavg  <= cnt_zero ? 23'd0 : r_cavg;
            r_o_empty <= cnt_zero;
            r_o_trunc <= r_trunc && emit_last;
            r_o_last  <= emit_last;
        end
    end

    assign o_cfg_ready                  = 1'b1;
    assign o_out_valid                  = r_ov;
    assign o_report_time                = r_o_time;
    assign o_packet_total               = r_o_total;
    assign o_wire_average_hundredths    = r_o_wavg;
    assign o_capture_average_hundredths = r_o_cavg;
    assign o_interval_empty             = r_o_empty;
    assign o_gap_truncated              = r_o_trunc;
    assign o_last_report                = r_o_last;

    a_beat_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_EMIT))
        else $error("report beat raised outside the emit state");

    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_left != '0))
        else $error("emit state entered with no reports left");

    a_empty_zero_avg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_interval_empty) |->
            (o_wire_average_hundredths == 23'd0 && o_capture_average_hundredths == 23'd0))
        else $error("empty interval reported nonzero average");

    a_trunc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_gap_truncated) |-> o_last_report)
        else $error("truncation flag on a report that is not the last");

endmodule

/* verif/interval_packet_length_averager_top_tb.sv */
// Self-checking testbench of the interval packet length averager top level.
`timescale 1ns / 100ps

module interval_packet_length_averager_top_tb;
    import ipla_pkg::*;

    localparam int   MAX_REPORTS   = 64;
    localparam int   SETTLE_CYCLES = 150;
    localparam int   STALL_LIMIT   = 6000;
    localparam int   LONG_HOLD     = 400;
    localparam int   RANDOM_BATCH  = 31;
    localparam logic OP_PACKET     = 1'b0;
    localparam logic OP_FLUSH      = 1'b1;

    typedef struct packed {
        logic        op;
        logic [31:0] ts;
        logic [15:0] wire_len;
        logic [15:0] cap_len;
    } record_t;

    typedef struct packed {
        logic [31:0] report_time;
        logic [31:0] packet_total;
        logic [22:0] wire_avg;
        logic [22:0] cap_avg;
        logic        empty;
        logic        truncated;
        logic        last;
    } report_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_operation = 1'b0;
    logic [31:0] i_timestamp_seconds = '0;
    logic [15:0] i_wire_length = '0;
    logic [15:0] i_capture_length = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [31:0] o_report_time;
    logic [31:0] o_packet_total;
    logic [22:0] o_wire_average_hundredths;
    logic [22:0] o_capture_average_hundredths;
    logic        o_interval_empty;
    logic        o_gap_truncated;
    logic        o_last_report;

    interval_packet_length_averager_top #(
        .MAX_REPORTS(MAX_REPORTS)
    ) dut (
        .i_clk                        (i_clk),
        .i_rst_n                      (i_rst_n),
        .i_cfg_valid                  (i_cfg_valid),
        .o_cfg_ready                  (o_cfg_ready),
        .i_cfg_data                   (i_cfg_data),
        .i_in_valid                   (i_in_valid),
        .o_in_ready                   (o_in_ready),
        .i_operation                  (i_operation),
        .i_timestamp_seconds          (i_timestamp_seconds),
        .i_wire_length                (i_wire_length),
        .i_capture_length             (i_capture_length),
        .o_out_valid                  (o_out_valid),
        .i_out_ready                  (i_out_ready),
        .o_report_time                (o_report_time),
        .o_packet_total               (o_packet_total),
        .o_wire_average_hundredths    (o_wire_average_hundredths),
        .o_capture_average_hundredths (o_capture_average_hundredths),
        .o_interval_empty             (o_interval_empty),
        .o_gap_truncated              (o_gap_truncated),
        .o_last_report                (o_last_report)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Records waiting to be sent and reports owed by the block.
    record_t     record_queue[$];
    report_t     due_reports[$];
    int          records_queued = 0;
    int          records_taken = 0;
    int          flush_count = 0;
    int          settings_used = 1;
    int          reports_seen = 0;
    int          empty_seen = 0;
    int          truncated_seen = 0;
    int          mismatches = 0;
    int          idle_cycles = 0;
    int          tx_pause = 0;
    int          tx_calm = 0;
    int          rx_pause = 0;
    int          rx_calm = 0;
    int          hold_left = 0;
    bit          hold_armed = 1'b0;
    bit          hold_done = 1'b0;
    record_t     next_rec;

    // Interval accounting state, mirrored from the block's behavior.
    logic [15:0] ivl_setting = IVL_RESET;
    bit          started = 1'b0;
    logic [31:0] boundary = '0;
    logic [31:0] pkt_count = '0;
    logic [47:0] wire_total = '0;
    logic [47:0] cap_total = '0;

    function automatic logic [31:0] sat32(input logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic logic [22:0] avg_x100(input logic [47:0] sum, input logic [31:0] cnt);
        logic [63:0] q;
        if (cnt == 0) begin
            return '0;
        end
        q = ({16'b0, sum} * 64'd100 + {33'b0, cnt[31:1]}) / {32'b0, cnt};
        if (q > {41'b0, AVG_MAX}) begin
            q = {41'b0, AVG_MAX};
        end
        return q[22:0];
    endfunction

    function automatic logic [47:0] add_len(input logic [47:0] sum, input logic [15:0] len);
        logic [48:0] s;
        s = {1'b0, sum} + {33'b0, len};
        return s[48] ? SUM_MAX : s[47:0];
    endfunction

    task automatic owe_report(input logic [31:0] t, input logic trunc, input logic last);
        report_t rep;
        rep.report_time  = t;
        rep.packet_total = pkt_count;
        rep.wire_avg     = avg_x100(wire_total, pkt_count);
        rep.cap_avg      = avg_x100(cap_total, pkt_count);
        rep.empty        = (pkt_count == 0);
        rep.truncated    = trunc;
        rep.last         = last;
        due_reports.push_back(rep);
        pkt_count  = '0;
        wire_total = '0;
        cap_total  = '0;
    endtask

    // Account one accepted record and queue the reports it closes.
    task automatic tally_record(input record_t r);
        logic [63:0] step;
        logic [63:0] gap;
        logic [63:0] k;
        logic [63:0] emit;
        logic [63:0] t;
        step = (ivl_setting == 0) ? 64'd1 : {48'b0, ivl_setting};
        if (r.op == OP_FLUSH) begin
            owe_report(started ? boundary : 32'd0, 1'b0, 1'b1);
            started  = 1'b0;
            boundary = '0;
            flush_count++;
            return;
        end
        if (!started) begin
            started  = 1'b1;
            boundary = sat32({32'b0, r.ts} + step);
        end
        if (r.ts > boundary) begin
            gap  = {32'b0, r.ts} - {32'b0, boundary};
            k    = (gap + step - 64'd1) / step;
            emit = (k > 64'(MAX_REPORTS)) ? 64'(MAX_REPORTS) : k;
            for (longint j = 0; j < emit; j++) begin
                t = {32'b0, boundary} + j * step;
                owe_report(t[31:0], (k > 64'(MAX_REPORTS)) && (j + 1 == emit), j + 1 == emit);
            end
            boundary = sat32({32'b0, boundary} + k * step);
        end
        if (pkt_count != CNT_MAX) begin
            pkt_count  = pkt_count + 32'd1;
            wire_total = add_len(wire_total, r.wire_len);
            cap_total  = add_len(cap_total, r.cap_len);
        end
    endtask

    // Mostly no pause, some short, a few long; now and then a calm stretch.
    function automatic int pick_pause(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 59) == 0) begin
            calm = $urandom_range(20, 50);
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 96) begin
            return $urandom_range(4, 12);
        end else begin
            return $urandom_range(25, 70);
        end
    endfunction

    function automatic logic [15:0] pick_length();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return 16'h0000;
        end else if (r == 1) begin
            return 16'hFFFF;
        end
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic push_record(input logic op, input logic [31:0] ts,
                               input logic [15:0] wl, input logic [15:0] cl);
        record_t rec;
        rec.op       = op;
        rec.ts       = ts;
        rec.wire_len = wl;
        rec.cap_len  = cl;
        record_queue.push_back(rec);
        records_queued++;
    endtask

    // Mostly forward-moving packet streams, with jumps, stragglers and flushes.
    task automatic push_random(input int n);
        logic [63:0] step;
        logic [63:0] now;
        logic [63:0] back;
        int          r;
        step = (ivl_setting == 0) ? 64'd1 : {48'b0, ivl_setting};
        now  = 64'($urandom_range(0, 32'hF000_0000));
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
                push_record(OP_FLUSH, $urandom, pick_length(), pick_length());
            end else if (r < 12) begin
                back = 64'($urandom_range(0, 32'(3 * step)));
                push_record(OP_PACKET, (now > back) ? 32'(now - back) : 32'd0,
                            pick_length(), pick_length());
            end else begin
                if (r < 20) begin
                    now += step * 64'($urandom_range(1, 4)) +
                           64'($urandom_range(0, 32'(step - 64'd1)));
                end else if (r < 23) begin
                    now += step * 64'($urandom_range(65, 300));
                end else if (r < 26) begin
                    now = 64'($urandom);
                end else begin
                    now += 64'($urandom_range(0, 32'(step / 64'd3 + 64'd1)));
                end
                if (now > 64'hFFFF_FFFF) begin
                    now = 64'hFFFF_FFFF;
                end
                push_record(OP_PACKET, now[31:0], pick_length(), pick_length());
            end
        end
    endtask

    // Let every record go in and every report come out, then let the block go quiet.
    task automatic settle();
        while (records_taken != records_queued || due_reports.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_interval(input logic [15:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do begin
            @(posedge i_clk);
        end while (!(i_cfg_valid && o_cfg_ready));
        ivl_setting = v;
        settings_used++;
        i_cfg_valid <= 1'b0;
    endtask

    // Record driver: account the beat taken at this edge, then offer the next one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                tally_record({i_operation, i_timestamp_seconds, i_wire_length,
                              i_capture_length});
                records_taken++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (tx_pause > 0) begin
                    tx_pause--;
                    i_in_valid <= 1'b0;
                end else if (record_queue.size() > 0) begin
                    next_rec = record_queue.pop_front();
                    i_in_valid          <= 1'b1;
                    i_operation         <= next_rec.op;
                    i_timestamp_seconds <= next_rec.ts;
                    i_wire_length       <= next_rec.wire_len;
                    i_capture_length    <= next_rec.cap_len;
                    tx_pause = pick_pause(tx_calm);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Report receiver: random back-pressure, plus one long hold while reports are due.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (hold_armed && !hold_done && due_reports.size() > 0) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
            i_out_ready <= 1'b0;
        end else if (rx_pause > 0) begin
            rx_pause--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            rx_pause = pick_pause(rx_calm);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        report_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            reports_seen++;
            if (o_interval_empty) begin
                empty_seen++;
            end
            if (o_gap_truncated) begin
                truncated_seen++;
            end
            if (due_reports.size() == 0) begin
                mismatches++;
                $display("%0t: report expected none actual report_time %0h total %0h",
                         $time, o_report_time, o_packet_total);
            end else begin
                want = due_reports.pop_front();
                check_field("report_time", want.report_time, o_report_time);
                check_field("packet_total", want.packet_total, o_packet_total);
                check_field("wire_average", 32'(want.wire_avg),
                            32'(o_wire_average_hundredths));
                check_field("capture_average", 32'(want.cap_avg),
                            32'(o_capture_average_hundredths));
                check_field("interval_empty", 32'(want.empty), 32'(o_interval_empty));
                check_field("gap_truncated", 32'(want.truncated), 32'(o_gap_truncated));
                check_field("last_report", 32'(want.last), 32'(o_last_report));
            end
        end
    end

    // Watchdog: end the run when no beat moves on any channel for too long.
    always @(posedge i_clk) begin
        if (i_rst_n && !((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                         (i_cfg_valid && o_cfg_ready))) begin
            idle_cycles++;
        end else begin
            idle_cycles = 0;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset interval of 10 s.
        push_record(OP_FLUSH, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        push_record(OP_PACKET, 32'd0, 16'd0, 16'd0);
        push_record(OP_PACKET, 32'd10, 16'hFFFF, 16'hFFFF);
        push_record(OP_PACKET, 32'd5, 16'd1, 16'd2);
        push_record(OP_PACKET, 32'd11, 16'd100, 16'd60);
        push_record(OP_PACKET, 32'd45, 16'd7, 16'd3);
        push_record(OP_FLUSH, 32'd0, 16'd0, 16'd0);
        push_record(OP_PACKET, 32'd100, 16'd1500, 16'd64);
        push_record(OP_PACKET, 32'd2100, 16'd40, 16'd40);
        push_record(OP_PACKET, 32'd2101, 16'd9, 16'd9);
        push_record(OP_FLUSH, 32'h1234_5678, 16'd5, 16'd5);
        push_record(OP_PACKET, 32'hFFFF_FFF0, 16'hFFFF, 16'd0);
        push_record(OP_PACKET, 32'hFFFF_FFFF, 16'd0, 16'hFFFF);
        push_record(OP_PACKET, 32'h7FFF_FFFF, 16'd12345, 16'd54321);
        push_record(OP_FLUSH, 32'd0, 16'd0, 16'd0);
        push_record(OP_PACKET, 32'hFFFF_FFF8, 16'd3, 16'd4);
        settle();

        // Zero interval behaves as one second.
        write_interval(16'd0);
        push_record(OP_PACKET, 32'h5555_AAAA, 16'd1, 16'd1);
        push_record(OP_PACKET, 32'h5555_AAAB, 16'd2, 16'd2);
        push_record(OP_PACKET, 32'h5555_AAAE, 16'd3, 16'd3);
        push_record(OP_PACKET, 32'h5555_AB72, 16'd4, 16'd4);
        push_record(OP_FLUSH, 32'd0, 16'd0, 16'd0);
        settle();

        write_interval(16'hFFFF);
        push_record(OP_PACKET, 32'hFFFF_0000, 16'd77, 16'd33);
        push_record(OP_PACKET, 32'hAAAA_5555, 16'd88, 16'd44);
        push_record(OP_FLUSH, 32'd0, 16'd0, 16'd0);
        push_random(RANDOM_BATCH);
        settle();

        write_interval(16'd1);
        hold_armed = 1'b1;
        push_random(RANDOM_BATCH);
        settle();

        write_interval(16'($urandom_range(2, 200)));
        push_random(RANDOM_BATCH);
        settle();

        write_interval(16'($urandom_range(201, 65534)));
        push_random(RANDOM_BATCH);
        settle();

        write_interval(IVL_RESET);
        push_random(RANDOM_BATCH);
        settle();

        $display("sent %0d records (%0d flushes) under %0d interval settings",
                 records_taken, flush_count, settings_used);
        $display("checked %0d reports, %0d of empty intervals, %0d cut short by the cap",
                 reports_seen, empty_seen, truncated_seen);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
